FILE: design/pra_pkg.sv
`timescale 1ns / 1ps

package pra_pkg;

    // Number of priority levels and width of each level's waiter count
    localparam int NUM_LEVELS = 11;
    localparam int WAIT_WIDTH = 8;
    localparam int LVL_IDX_W  = $clog2(NUM_LEVELS);

    localparam logic [WAIT_WIDTH-1:0] WAIT_MAX = {WAIT_WIDTH{1'b1}};

    // Field widths fixed by the interface
    localparam int LEVEL_W = 4;
    localparam int UNITS_W = 8;

    localparam logic [UNITS_W-1:0] MAX_UNITS_RESET = 8'd3;

    // Operation codes
    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [LEVEL_W-1:0] priority_req;
    } pra_in_t;

    typedef struct packed {
        logic               granted;
        logic               queued;
        logic               rejected;
        logic [LEVEL_W-1:0] handed_level;
        logic [UNITS_W-1:0] free_units;
    } pra_out_t;

endpackage

FILE: design/priority_resource_allocator.sv
`timescale 1ns / 1ps

// Counting resource allocator with per-level waiter counts. One transaction
// (request or release) is accepted per clock cycle when the output side keeps
// up. A transaction is first held in the input register; the allocation
// decision (priority encoder over the eleven levels plus counter updates)
// then loads the result register, which raises out_valid and holds the
// result until it is taken.
// A stalled output holds its result while one more transaction waits in the
// input register. max_units may only be written while no transaction is in
// flight; writing it never adjusts the current free count.
module priority_resource_allocator
    import pra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pra_in_t            in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pra_out_t           out_data,
    input  logic               cfg_we,
    input  logic [UNITS_W-1:0] cfg_wdata
);

    logic     in_valid_reg;
    pra_in_t  in_data_reg;
    logic     out_valid_reg;
    pra_out_t out_data_reg;
    logic     advance;
    pra_out_t result;

    // Input stage moves forward when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    pra_alloc u_alloc (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_data_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: design/pra_prio_enc.sv
`timescale 1ns / 1ps

module pra_prio_enc
    import pra_pkg::*;
(
    input  logic [NUM_LEVELS-1:0] req,
    output logic                  any,
    output logic [LVL_IDX_W-1:0]  idx
);

    // Highest set bit wins: later iterations override earlier ones
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (req[i])
            begin
                idx = LVL_IDX_W'(i);
            end
        end
    end

    assign any = |req;

endmodule

FILE: design/pra_alloc.sv
`timescale 1ns / 1ps

module pra_alloc
    import pra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  pra_in_t            item,
    input  logic               cfg_we,
    input  logic [UNITS_W-1:0] cfg_wdata,
    output pra_out_t           result
);

    logic [UNITS_W-1:0]    max_units_reg;
    logic [UNITS_W-1:0]    free_count_reg;
    logic [UNITS_W-1:0]    free_count_next;
    logic [WAIT_WIDTH-1:0] wait_reg [NUM_LEVELS];

    logic [NUM_LEVELS-1:0] nonzero;
    logic [NUM_LEVELS-1:0] full;
    logic                  waiter_any;
    logic [LVL_IDX_W-1:0]  waiter_idx;
    logic                  lvl_ok;
    logic [LVL_IDX_W-1:0]  lvl_idx;
    logic                  do_inc;
    logic                  do_dec;

    // Per-level status flags
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            nonzero[i] = (wait_reg[i] != '0);
            full[i]    = (wait_reg[i] == WAIT_MAX);
        end
    end

    // Highest level that has waiters
    pra_prio_enc u_prio_enc (
        .req (nonzero),
        .any (waiter_any),
        .idx (waiter_idx)
    );

    assign lvl_ok  = (32'(item.priority_req) < 32'(NUM_LEVELS));
    assign lvl_idx = LVL_IDX_W'(item.priority_req);

    // Request / release decision
    always_comb
    begin
        result          = '0;
        free_count_next = free_count_reg;
        do_inc          = 1'b0;
        do_dec          = 1'b0;
        if (item.func == FUNC_REQUEST)
        begin
            if (!lvl_ok)
            begin
                result.rejected = 1'b1;
            end
            else if (free_count_reg != '0)
            begin
                free_count_next = free_count_reg - 1'b1;
                result.granted  = 1'b1;
            end
            else if (!full[lvl_idx])
            begin
                do_inc        = 1'b1;
                result.queued = 1'b1;
            end
            else
            begin
                result.rejected = 1'b1;
            end
        end
        else
        begin
            if (waiter_any)
            begin
                do_dec              = 1'b1;
                result.granted      = 1'b1;
                result.handed_level = LEVEL_W'(waiter_idx);
            end
            else if (free_count_reg >= max_units_reg)
            begin
                result.rejected = 1'b1;
            end
            else
            begin
                free_count_next = free_count_reg + 1'b1;
            end
        end
        result.free_units = free_count_next;
    end

    // Limit and free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_reg  <= MAX_UNITS_RESET;
            free_count_reg <= MAX_UNITS_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                max_units_reg <= cfg_wdata;
            end
            if (step)
            begin
                free_count_reg <= free_count_next;
            end
        end
    end

    // One waiter counter per level
    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_lane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                wait_reg[g] <= '0;
            end
            else if (step)
            begin
                if (do_inc && (lvl_idx == LVL_IDX_W'(g)))
                begin
                    wait_reg[g] <= wait_reg[g] + 1'b1;
                end
                else if (do_dec && (waiter_idx == LVL_IDX_W'(g)))
                begin
                    wait_reg[g] <= wait_reg[g] - 1'b1;
                end
            end
        end
    end

    // Checks
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> $onehot0({result.granted, result.queued, result.rejected}))
        else $error("more than one outcome flag set");

    a_queue_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.queued) |-> (free_count_reg == '0))
        else $error("request queued while units were free");

    a_free_stable_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(free_count_reg))
        else $error("free count changed without a transaction");

endmodule
